>>> hw/rtl/owtr_pkg.sv
`default_nettype none

package owtr_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int TICK_W      = 10;

   localparam int SCRATCHPAD_BYTES_DEFAULT = 9;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RESET_RECOVER = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOT_LOW      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_READ_SAMPLE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_READ_TAIL     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_WRITE_HOLD    = 3'd6;

   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_PAD = 8'hBE;

   typedef struct packed {
      logic [9:0] reset_low_ticks;
      logic [7:0] presence_wait_ticks;
      logic [9:0] reset_recover_ticks;
      logic [5:0] slot_low_ticks;
      logic [5:0] read_sample_ticks;
      logic [7:0] read_tail_ticks;
      logic [7:0] write_hold_ticks;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      reset_low_ticks:     10'd500,
      presence_wait_ticks: 8'd80,
      reset_recover_ticks: 10'd500,
      slot_low_ticks:      6'd4,
      read_sample_ticks:   6'd10,
      read_tail_ticks:     8'd60,
      write_hold_ticks:    8'd80
   };

endpackage

`default_nettype wire

>>> hw/rtl/owtr_req_if.sv
`default_nettype none

interface owtr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic       line_level;

   modport source (output valid, output mode, output line_level, input ready);
   modport sink   (input valid, input mode, input line_level, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/owtr_rsp_if.sv
`default_nettype none

interface owtr_rsp_if;
   logic        valid;
   logic        ready;
   logic        drive_low;
   logic        busy_res;
   logic        done_res;
   logic        device_present;
   logic [15:0] temperature_tenths;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output device_present, output temperature_tenths, input ready);
   modport sink   (input valid, input drive_low, input busy_res, input done_res,
                   input device_present, input temperature_tenths, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/one_wire_temp_sensor_reader_unit.sv
// channel   | modport | carries
// ----------+---------+-----------------------------------------------------
// req_bus   | sink    | mode, line_level: one bus tick per transaction
// rsp_bus   | source  | drive_low, busy_res, done_res, device_present,
//           |         | temperature_tenths: one result per tick
// csr_*     | write   | csr_we, csr_index, csr_wdata, no read-back
//
// one tick per cycle unless stalled: the sequencer step and its counter
// update in the cycle the transaction is taken, and the result lands in the
// output register, which frees up the same cycle it is read, so
// req_bus.ready drops only while a result is held and rsp_bus.ready is low.
// reset (synchronous, active high) empties the output register, idles the
// sequencer and loads the default slot timings.
`default_nettype none

module one_wire_temp_sensor_reader_unit #(
   parameter int SCRATCHPAD_BYTES = owtr_pkg::SCRATCHPAD_BYTES_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   owtr_req_if.sink                           req_bus,
   owtr_rsp_if.source                         rsp_bus,
   input  wire                                csr_we,
   input  wire  [owtr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [owtr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_RST_LOW   = 4'd1;
   localparam logic [3:0] ST_PRES_WAIT = 4'd2;
   localparam logic [3:0] ST_RECOVER   = 4'd3;
   localparam logic [3:0] ST_WR_LOW    = 4'd4;
   localparam logic [3:0] ST_WR_HOLD   = 4'd5;
   localparam logic [3:0] ST_WR_GAP    = 4'd6;
   localparam logic [3:0] ST_RD_LOW    = 4'd7;
   localparam logic [3:0] ST_RD_WAIT   = 4'd8;
   localparam logic [3:0] ST_RD_TAIL   = 4'd9;

   localparam logic [3:0] LAST_BYTES = 4'(SCRATCHPAD_BYTES);

   owtr_pkg::cfg_type cfg_ff;

   logic [3:0]                    step_ff, step_in;
   logic [owtr_pkg::TICK_W-1:0]   tick_ff, tick_in;
   logic [3:0]                    byte_ff, byte_in;
   logic [2:0]                    bit_ff, bit_in;
   logic [7:0]                    shift_ff, shift_in;
   logic [7:0]                    low_ff, low_in;
   logic                          rd_seq_ff, rd_seq_in;
   logic                          pres_ff, pres_in;
   logic [15:0]                   temp_ff, temp_in;

   logic        rsp_valid_ff;
   logic        drive_ff, drive_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic        req_take;
   logic [3:0]  step_cur;
   logic [3:0]  byte_cur;
   logic [2:0]  bit_cur;
   logic        rd_cur;
   logic [owtr_pkg::TICK_W-1:0] tick_cur;
   logic [owtr_pkg::TICK_W-1:0] limit;
   logic [owtr_pkg::TICK_W:0]   tick_sum;
   logic        last;
   logic [owtr_pkg::TICK_W-1:0] tick_adv;
   logic [7:0]  cmd;
   logic [3:0]  byte_inc;
   logic [15:0] raw;
   logic [18:0] raw_x5;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_take      = req_bus.valid && req_bus.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= owtr_pkg::CFG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            owtr_pkg::REG_RESET_LOW:     cfg_ff.reset_low_ticks     <= csr_wdata[9:0];
            owtr_pkg::REG_PRESENCE_WAIT: cfg_ff.presence_wait_ticks <= csr_wdata[7:0];
            owtr_pkg::REG_RESET_RECOVER: cfg_ff.reset_recover_ticks <= csr_wdata[9:0];
            owtr_pkg::REG_SLOT_LOW:      cfg_ff.slot_low_ticks      <= csr_wdata[5:0];
            owtr_pkg::REG_READ_SAMPLE:   cfg_ff.read_sample_ticks   <= csr_wdata[5:0];
            owtr_pkg::REG_READ_TAIL:     cfg_ff.read_tail_ticks     <= csr_wdata[7:0];
            owtr_pkg::REG_WRITE_HOLD:    cfg_ff.write_hold_ticks    <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // command launch
   always_comb begin
      step_cur = step_ff;
      tick_cur = tick_ff;
      byte_cur = byte_ff;
      bit_cur  = bit_ff;
      rd_cur   = rd_seq_ff;
      if (step_ff == ST_IDLE &&
          (req_bus.mode == owtr_pkg::MODE_START || req_bus.mode == owtr_pkg::MODE_READ)) begin
         step_cur = ST_RST_LOW;
         tick_cur = '0;
         byte_cur = '0;
         bit_cur  = '0;
         rd_cur   = (req_bus.mode == owtr_pkg::MODE_READ);
      end
   end

   // phase timer
   always_comb begin
      case (step_cur)
         ST_RST_LOW:   limit = cfg_ff.reset_low_ticks;
         ST_PRES_WAIT: limit = {2'b00, cfg_ff.presence_wait_ticks};
         ST_RECOVER:   limit = cfg_ff.reset_recover_ticks;
         ST_WR_LOW:    limit = {4'b0000, cfg_ff.slot_low_ticks};
         ST_RD_LOW:    limit = {4'b0000, cfg_ff.slot_low_ticks};
         ST_WR_HOLD:   limit = {2'b00, cfg_ff.write_hold_ticks};
         ST_RD_WAIT:   limit = {4'b0000, cfg_ff.read_sample_ticks};
         ST_RD_TAIL:   limit = {2'b00, cfg_ff.read_tail_ticks};
         default:      limit = '0;
      endcase
   end

   assign tick_sum = {1'b0, tick_cur} + 11'd1;
   assign last     = tick_sum >= {1'b0, limit};
   assign tick_adv = last ? '0 : tick_sum[owtr_pkg::TICK_W-1:0];

   assign cmd = (byte_cur == 4'd0) ? owtr_pkg::CMD_SKIP_ROM :
                (rd_cur ? owtr_pkg::CMD_READ_PAD : owtr_pkg::CMD_CONVERT);

   assign byte_inc = byte_cur + 4'd1;
   assign raw      = {shift_ff, low_ff};
   assign raw_x5   = {3'b000, raw} + {1'b0, raw, 2'b00};

   // sequencer
   always_comb begin
      step_in   = step_cur;
      tick_in   = tick_cur;
      byte_in   = byte_cur;
      bit_in    = bit_cur;
      rd_seq_in = rd_cur;
      shift_in  = shift_ff;
      low_in    = low_ff;
      pres_in   = pres_ff;
      temp_in   = temp_ff;
      drive_in  = 1'b0;
      busy_in   = (step_cur != ST_IDLE);
      done_in   = 1'b0;
      case (step_cur)
         ST_IDLE: begin
         end
         ST_RST_LOW: begin
            drive_in = 1'b1;
            tick_in  = tick_adv;
            if (last) step_in = ST_PRES_WAIT;
         end
         ST_PRES_WAIT: begin
            tick_in = tick_adv;
            if (last) begin
               pres_in = !req_bus.line_level;
               step_in = ST_RECOVER;
            end
         end
         ST_RECOVER: begin
            tick_in = tick_adv;
            if (last) step_in = ST_WR_LOW;
         end
         ST_WR_LOW: begin
            drive_in = 1'b1;
            tick_in  = tick_adv;
            if (last) step_in = ST_WR_HOLD;
         end
         ST_WR_HOLD: begin
            drive_in = !cmd[bit_cur];
            tick_in  = tick_adv;
            if (last) step_in = ST_WR_GAP;
         end
         ST_WR_GAP: begin
            tick_in = '0;
            if (bit_cur != 3'd7) begin
               bit_in  = bit_cur + 3'd1;
               step_in = ST_WR_LOW;
            end else begin
               bit_in = '0;
               if (byte_inc < 4'd2) begin
                  byte_in = byte_inc;
                  step_in = ST_WR_LOW;
               end else if (rd_cur) begin
                  byte_in  = '0;
                  shift_in = '0;
                  step_in  = ST_RD_LOW;
               end else begin
                  byte_in = '0;
                  done_in = 1'b1;
                  step_in = ST_IDLE;
               end
            end
         end
         ST_RD_LOW: begin
            drive_in = 1'b1;
            tick_in  = tick_adv;
            if (last) step_in = ST_RD_WAIT;
         end
         ST_RD_WAIT: begin
            tick_in = tick_adv;
            if (last) begin
               shift_in = {req_bus.line_level, shift_ff[7:1]};
               step_in  = ST_RD_TAIL;
            end
         end
         ST_RD_TAIL: begin
            tick_in = tick_adv;
            if (last) begin
               if (bit_cur != 3'd7) begin
                  bit_in  = bit_cur + 3'd1;
                  step_in = ST_RD_LOW;
               end else begin
                  bit_in = '0;
                  if (byte_cur == 4'd0) begin
                     low_in = shift_ff;
                  end else if (byte_cur == 4'd1) begin
                     temp_in = raw_x5[18:3];
                  end
                  if (byte_inc >= LAST_BYTES) begin
                     byte_in = '0;
                     done_in = 1'b1;
                     step_in = ST_IDLE;
                  end else begin
                     byte_in = byte_inc;
                     step_in = ST_RD_LOW;
                  end
               end
            end
         end
         default: begin
            step_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= ST_IDLE;
         tick_ff   <= '0;
         byte_ff   <= '0;
         bit_ff    <= '0;
         shift_ff  <= '0;
         low_ff    <= '0;
         rd_seq_ff <= 1'b0;
         pres_ff   <= 1'b0;
         temp_ff   <= '0;
      end else if (req_take) begin
         step_ff   <= step_in;
         tick_ff   <= tick_in;
         byte_ff   <= byte_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         low_ff    <= low_in;
         rd_seq_ff <= rd_seq_in;
         pres_ff   <= pres_in;
         temp_ff   <= temp_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         drive_ff <= drive_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.drive_low          = drive_ff;
   assign rsp_bus.busy_res           = busy_ff;
   assign rsp_bus.done_res           = done_ff;
   assign rsp_bus.device_present     = pres_ff;
   assign rsp_bus.temperature_tenths = temp_ff;

   a_done_in_seq : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> busy_ff)
      else $error("done without busy");

   a_drive_in_seq : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && drive_ff |-> busy_ff)
      else $error("line driven outside a sequence");

   a_plain_idle : assert property (@(posedge clock) disable iff (reset)
      req_take && step_ff == ST_IDLE &&
      req_bus.mode != owtr_pkg::MODE_START && req_bus.mode != owtr_pkg::MODE_READ
      |=> !busy_ff && !drive_ff && step_ff == ST_IDLE)
      else $error("plain tick left idle");

   a_temp_only_reading : assert property (@(posedge clock) disable iff (reset)
      req_take && step_ff != ST_RD_TAIL |=> $stable(temp_ff))
      else $error("temperature changed outside a read");

endmodule

`default_nettype wire
